/* src/fdbei_pkg.sv */
// Shared types, constants and the xorshift32 step for the frame drop and
// bit error injector. No dependencies.
`default_nettype none

package fdbei_pkg;

   // byte width and one flip lane per bit
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned LANES      = BYTE_WIDTH;
   localparam int unsigned FLIPS_WIDTH = 4;

   localparam int unsigned COUNTER_WIDTH_DEFAULT = 32;
   localparam int unsigned OUT_CNT_WIDTH = 32;

   // xorshift32 shift amounts
   localparam int unsigned XS_SHL_A = 13;
   localparam int unsigned XS_SHR_B = 17;
   localparam int unsigned XS_SHL_C = 5;

   // CSR map
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DROP  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ERROR = 2'd2;

   localparam logic [31:0] SEED_RESET = 32'd1;

   // payload of the decision stage, handed to the merge stage
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data;
      logic [BYTE_WIDTH-1:0] flip_mask;
      logic                  dropped;
      logic                  pass;    // byte of a kept, non-empty item
      logic                  start;   // item opens a frame
      logic                  last;
   } stage_type;

   function automatic logic [31:0] xs_step(input logic [31:0] s);
      logic [31:0] t;
      t = s ^ (s << XS_SHL_A);
      t = t ^ (t >> XS_SHR_B);
      t = t ^ (t << XS_SHL_C);
      return t;
   endfunction

endpackage

`default_nettype wire

/* src/fdbei_lane.sv */
// One bit lane: advances the draw chain by one xorshift step and compares
// the draw with the error threshold. Depends on fdbei_pkg.
`default_nettype none

module fdbei_lane
   import fdbei_pkg::*;
(
   input  wire logic [31:0] draw_prev,
   input  wire logic [31:0] err_thr,
   output logic      [31:0] draw,
   output logic             hit
);

   always_comb begin
      draw = xs_step(draw_prev);
      hit  = {1'b0, draw[31:1]} < err_thr;
   end

endmodule

`default_nettype wire

/* src/fdbei_front.sv */
// Generator state, frame drop decision and the decision stage register.
// Takes the lane results back in. Depends on fdbei_pkg.
`default_nettype none

module fdbei_front
   import fdbei_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BYTE_WIDTH-1:0] data_in,
   input  wire logic                  frame_first,
   input  wire logic                  frame_last,
   input  wire logic                  empty_frame,
   input  wire logic [31:0]           drop_thr,
   input  wire logic [31:0]           err_thr,
   input  wire logic                  seed_load,
   input  wire logic [31:0]           seed_data,
   input  wire logic [LANES-1:0]      lane_hits,   // indexed by data bit
   input  wire logic [31:0]           draw_last,
   output logic      [31:0]           draw_base,
   input  wire logic                  advance,
   output logic                       stage_valid,
   output stage_type                  stage
);

   logic [31:0] gen_ff, gen_in;
   logic        dropping_ff, dropping_in;
   logic        stage_valid_ff, stage_valid_in;
   stage_type   stage_ff;

   logic [31:0] s1;
   logic        take, start, draw_taken, drop_now, dropped, keep;

   assign req_tready  = !stage_valid_ff || advance;
   assign take        = req_tvalid && req_tready;
   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   always_comb begin
      s1         = xs_step(gen_ff);
      start      = frame_first || empty_frame;
      // threshold 0 never drops, 2^31 and above always; neither takes a draw
      draw_taken = start && (drop_thr != '0) && !drop_thr[31];
      drop_now   = drop_thr[31] || ((drop_thr != '0) && ({1'b0, s1[31:1]} < drop_thr));
      dropped    = start ? drop_now : dropping_ff;
      keep       = !empty_frame && !dropped && (err_thr != '0);
      draw_base  = draw_taken ? s1 : gen_ff;
   end

   always_comb begin
      gen_in = gen_ff;
      if (seed_load) begin
         gen_in = (seed_data != '0) ? seed_data : SEED_RESET;
      end else if (take) begin
         gen_in = keep ? draw_last : draw_base;
      end
      dropping_in = (take && frame_first && !empty_frame) ? drop_now : dropping_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff         <= SEED_RESET;
         dropping_ff    <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         gen_ff         <= gen_in;
         dropping_ff    <= dropping_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff.data      <= data_in;
         stage_ff.flip_mask <= keep ? lane_hits : '0;
         stage_ff.dropped   <= dropped;
         stage_ff.pass      <= !empty_frame && !dropped;
         stage_ff.start     <= start;
         stage_ff.last      <= frame_last;
      end
   end

`ifndef SYNTHESIS
   // xorshift never reaches zero from a non-zero state
   assert property (@(posedge clock) disable iff (reset) gen_ff != '0)
      else $error("generator state is zero");
   // flips only ever land on bytes that are passed through
   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_ff.pass |-> stage_ff.flip_mask == '0)
      else $error("flip mask set on dropped or empty item");
`endif

endmodule

`default_nettype wire

/* src/fdbei_merge.sv */
// Merge stage: applies the lane flip mask, counts flips, keeps the frame
// and bit counters and holds the result register. Depends on fdbei_pkg.
`default_nettype none

module fdbei_merge
   import fdbei_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     stage_valid,
   input  wire stage_type                stage,
   input  wire logic                     clear,
   output logic                          advance,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic [BYTE_WIDTH-1:0]         data_out,
   output logic                          frame_dropped,
   output logic [FLIPS_WIDTH-1:0]        flips_in_byte,
   output logic                          end_of_frame,
   output logic [OUT_CNT_WIDTH-1:0]      sent_frames,
   output logic [OUT_CNT_WIDTH-1:0]      received_frames,
   output logic [OUT_CNT_WIDTH-1:0]      lost_frames,
   output logic [OUT_CNT_WIDTH-1:0]      flipped_bits
);

   logic [COUNTER_WIDTH-1:0] sent_ff, sent_in, recv_ff, recv_in;
   logic [COUNTER_WIDTH-1:0] lost_ff, lost_in, flip_ff, flip_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BYTE_WIDTH-1:0]    data_ff;
   logic                     dropped_ff, last_ff;
   logic [FLIPS_WIDTH-1:0]   flips_ff, flips;
   logic [OUT_CNT_WIDTH-1:0] sent_out_ff, recv_out_ff, lost_out_ff, flip_out_ff;
   logic [63:0]              sent_wide, recv_wide, lost_wide, flip_wide;
   logic                     move;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign move    = stage_valid && advance;

   always_comb begin
      flips = '0;
      for (int i = 0; i < LANES; i++) begin
         flips = flips + FLIPS_WIDTH'(stage.flip_mask[i]);
      end
      sent_in = sent_ff + COUNTER_WIDTH'(stage.start);
      recv_in = recv_ff + COUNTER_WIDTH'(stage.start && !stage.dropped);
      lost_in = lost_ff + COUNTER_WIDTH'(stage.start && stage.dropped);
      flip_in = flip_ff + COUNTER_WIDTH'(flips);
      sent_wide = 64'(sent_in);
      recv_wide = 64'(recv_in);
      lost_wide = 64'(lost_in);
      flip_wide = 64'(flip_in);
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         sent_ff <= '0;
         recv_ff <= '0;
         lost_ff <= '0;
         flip_ff <= '0;
      end else if (move) begin
         sent_ff <= sent_in;
         recv_ff <= recv_in;
         lost_ff <= lost_in;
         flip_ff <= flip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         data_ff     <= stage.pass ? (stage.data ^ stage.flip_mask) : '0;
         dropped_ff  <= stage.dropped;
         flips_ff    <= flips;
         last_ff     <= stage.last;
         sent_out_ff <= sent_wide[OUT_CNT_WIDTH-1:0];
         recv_out_ff <= recv_wide[OUT_CNT_WIDTH-1:0];
         lost_out_ff <= lost_wide[OUT_CNT_WIDTH-1:0];
         flip_out_ff <= flip_wide[OUT_CNT_WIDTH-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign data_out        = data_ff;
   assign frame_dropped   = dropped_ff;
   assign flips_in_byte   = flips_ff;
   assign end_of_frame    = last_ff;
   assign sent_frames     = sent_out_ff;
   assign received_frames = recv_out_ff;
   assign lost_frames     = lost_out_ff;
   assign flipped_bits    = flip_out_ff;

`ifndef SYNTHESIS
   // every counted frame is either delivered or lost
   assert property (@(posedge clock) disable iff (reset) sent_ff == recv_ff + lost_ff)
      else $error("frame counters out of balance");
   // counters move only with a beat into the result register or a seed write
   assert property (@(posedge clock) disable iff (reset)
      !move && !clear |=> $stable(sent_ff) && $stable(flip_ff))
      else $error("counter changed without a beat");
`endif

endmodule

`default_nettype wire

/* src/frame_drop_and_bit_error_injector_core.sv */
// Top level of the frame drop and bit error injector: CSR decode, the
// decision stage, eight flip lanes and the merge stage.
// Depends on fdbei_pkg, fdbei_front, fdbei_lane and fdbei_merge.
//
// Usage notes:
//  - req_*: one byte per beat. tuser[0] marks the first byte of a frame,
//    tuser[1] a whole zero-length frame, tlast the last byte.
//  - rsp_*: one result beat per request beat, in order. tuser is the frame
//    dropped flag, tlast copies the request tlast.
//  - csr_*: register writes (0 seed, 1 drop threshold, 2 error threshold),
//    always ready; write only while no beat is in flight. A seed write
//    reloads the generator and clears the four counters.
//  - Pipeline: two register stages. An accepted beat is held in the decision
//    stage register, then in the result register, from which rsp is driven.
//  - Throughput: one beat per cycle while rsp_tready is high. The frame
//    decision, the nine chained xorshift steps and the state update are
//    combinational up to the generator register; the lanes compare in the
//    same cycle; the merge stage counts and applies flips from stage_ff.
//  - Stall: the decision stage and the result register form a two-deep
//    pipe, so one more beat is taken while a result waits; req_tready
//    drops only when both are full and rsp_tready is low.
//  - Reset: generator loads 1, thresholds and counters clear, pipe empties.
`default_nettype none

module frame_drop_and_bit_error_injector_core
   import fdbei_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request stream
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,   // [7:0] data_in
   input  wire logic [1:0]                 req_tuser,   // [0] frame_first, [1] empty_frame
   input  wire logic                       req_tlast,   // frame_last
   // result stream
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [7:0] data_out, [11:8] flips_in_byte, [43:12] sent_frames,
   // [75:44] received_frames, [107:76] lost_frames, [139:108] flipped_bits,
   // [143:140] zero
   output logic [143:0]                    rsp_tdata,
   output logic                            rsp_tuser,   // frame_dropped
   output logic                            rsp_tlast,   // end_of_frame
   // register writes
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                csr_wdata
);

   logic [31:0]      drop_thr_ff, drop_thr_in, err_thr_ff, err_thr_in;
   logic             csr_write, seed_load;

   logic [31:0]      draw_base;
   logic [31:0]      draw_chain [LANES+1];
   logic [LANES-1:0] lane_hits;
   logic             advance, stage_valid;
   stage_type        stage;

   logic [BYTE_WIDTH-1:0]    data_out;
   logic                     frame_dropped, end_of_frame;
   logic [FLIPS_WIDTH-1:0]   flips_in_byte;
   logic [OUT_CNT_WIDTH-1:0] sent_frames, received_frames, lost_frames, flipped_bits;

   // register writes
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      drop_thr_in = drop_thr_ff;
      err_thr_in  = err_thr_ff;
      seed_load   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SEED:  seed_load   = 1'b1;
            CSR_DROP:  drop_thr_in = csr_wdata;
            CSR_ERROR: err_thr_in  = csr_wdata;
            default:   ;  // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_thr_ff <= '0;
         err_thr_ff  <= '0;
      end else begin
         drop_thr_ff <= drop_thr_in;
         err_thr_ff  <= err_thr_in;
      end
   end

   fdbei_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .data_in     (req_tdata),
      .frame_first (req_tuser[0]),
      .frame_last  (req_tlast),
      .empty_frame (req_tuser[1]),
      .drop_thr    (drop_thr_ff),
      .err_thr     (err_thr_ff),
      .seed_load   (seed_load),
      .seed_data   (csr_wdata),
      .lane_hits   (lane_hits),
      .draw_last   (draw_chain[LANES]),
      .draw_base   (draw_base),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   // lane i takes draw i+1 of the byte and decides data bit 7-i (MSB first)
   assign draw_chain[0] = draw_base;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      fdbei_lane u_lane (
         .draw_prev (draw_chain[i]),
         .err_thr   (err_thr_ff),
         .draw      (draw_chain[i+1]),
         .hit       (lane_hits[LANES-1-i])
      );
   end

   fdbei_merge #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .stage_valid     (stage_valid),
      .stage           (stage),
      .clear           (seed_load),
      .advance         (advance),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .data_out        (data_out),
      .frame_dropped   (frame_dropped),
      .flips_in_byte   (flips_in_byte),
      .end_of_frame    (end_of_frame),
      .sent_frames     (sent_frames),
      .received_frames (received_frames),
      .lost_frames     (lost_frames),
      .flipped_bits    (flipped_bits)
   );

   assign rsp_tdata = {4'b0000, flipped_bits, lost_frames, received_frames,
                       sent_frames, flips_in_byte, data_out};
   assign rsp_tuser = frame_dropped;
   assign rsp_tlast = end_of_frame;

`ifndef SYNTHESIS
   // a waiting result never leaves the request side blocked on its own
   assert property (@(posedge clock) disable iff (reset) !stage_valid |-> req_tready)
      else $error("request side stalled with empty decision stage");
   // a beat into the decision stage while the result is stuck needs it empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && stage_valid |-> !req_tready)
      else $error("pipe overrun while result stalled");
`endif

endmodule

`default_nettype wire
